FILE: src/cia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

   localparam int unsigned CountWidth = 12;
   localparam int unsigned WorkWidth = 13;
   localparam int unsigned DayWidth = 15;

   typedef enum logic [2:0] {
      UNIT_SECOND = 3'd0,
      UNIT_MINUTE = 3'd1,
      UNIT_HOUR   = 3'd2,
      UNIT_DAY    = 3'd3,
      UNIT_WEEK   = 3'd4,
      UNIT_MONTH  = 3'd5,
      UNIT_YEAR   = 3'd6,
      UNIT_NONE   = 3'd7
   } unit_type;

   localparam logic CSR_STEP_UNIT = 1'b0;
   localparam logic CSR_STEP_COUNT = 1'b1;

   localparam unit_type UNIT_RESET = UNIT_SECOND;
   localparam logic [CountWidth-1:0] COUNT_RESET = 12'd90;

   localparam logic [WorkWidth-1:0] SEC_WRAP = 13'd60;
   localparam logic [WorkWidth-1:0] MIN_WRAP = 13'd60;
   localparam logic [WorkWidth-1:0] HOUR_WRAP = 13'd24;
   localparam logic [WorkWidth-1:0] MON_WRAP = 13'd12;
   localparam logic [WorkWidth-1:0] CYCLE_YEARS = 13'd400;
   localparam logic [WorkWidth-1:0] CYCLE_LAST = 13'd399;
   localparam logic [WorkWidth-1:0] BASE_IN_CYCLE = 13'd300;
   localparam logic [WorkWidth-1:0] CENTURY_1 = 13'd100;
   localparam logic [WorkWidth-1:0] CENTURY_2 = 13'd200;
   localparam logic [WorkWidth-1:0] CENTURY_3 = 13'd300;
   localparam logic [WorkWidth-1:0] LAST_MONTH = 13'd11;

   typedef struct packed {
      logic [5:0] in_second;
      logic [5:0] in_minute;
      logic [4:0] in_hour;
      logic [4:0] in_day;
      logic [3:0] in_month;
      logic [9:0] in_year;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_second;
      logic [5:0]  out_minute;
      logic [4:0]  out_hour;
      logic [4:0]  out_day;
      logic [3:0]  out_month;
      logic [12:0] out_year;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic run_norm;
      logic run_days;
      logic capture;
   } cmd_type;

   typedef struct packed {
      logic norm_done;
      logic days_done;
   } status_type;

   function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      case (mon)
         4'd1: begin
            len = leap ? 5'd29 : 5'd28;
         end
         4'd3, 4'd5, 4'd8, 4'd10: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

FILE: src/cia_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cia_ctrl
   import cia_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_NORM = 3'b010,
      ST_DAYS = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            cmd.run_norm = 1'b1;
            if (status.norm_done) begin
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            cmd.run_days = 1'b1;
            if (status.days_done && out_free) begin
               cmd.capture = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.capture || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: src/cia_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cia_datapath
   import cia_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CountWidth-1:0] csr_wdata,
   input  wire req_type               req_data,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output rsp_type                    rsp_data
);

   unit_type unit_ff;
   logic [CountWidth-1:0] count_ff;

   logic [WorkWidth-1:0] sec_ff, sec_in, min_ff, min_in, hour_ff, hour_in;
   logic [WorkWidth-1:0] mon_ff, mon_in, year_ff, year_in, ymod_ff, ymod_in;
   logic [DayWidth-1:0]  day_ff, day_in;
   rsp_type              rsp_ff;

   logic [WorkWidth-1:0] n_ext, add_sec, add_min, add_hour, add_mon, add_year, year_ld;
   logic [DayWidth-1:0]  add_day;
   logic sc, mc, hc, oc, yc;
   logic leap, day_big;
   logic [4:0] mlen;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_STEP_UNIT) begin
            unit_ff <= unit_type'(csr_wdata[2:0]);
         end else begin
            count_ff <= csr_wdata;
         end
      end
   end

   assign n_ext = {1'b0, count_ff};
   assign add_sec = (unit_ff == UNIT_SECOND) ? n_ext : '0;
   assign add_min = (unit_ff == UNIT_MINUTE) ? n_ext : '0;
   assign add_hour = (unit_ff == UNIT_HOUR) ? n_ext : '0;
   assign add_mon = (unit_ff == UNIT_MONTH) ? n_ext : '0;
   assign add_year = (unit_ff == UNIT_YEAR) ? n_ext : '0;
   always_comb begin
      case (unit_ff)
         UNIT_DAY: add_day = {3'b000, count_ff};
         UNIT_WEEK: add_day = {count_ff, 3'b000} - {3'b000, count_ff};
         default: add_day = '0;
      endcase
   end
   assign year_ld = WorkWidth'(req_data.in_year) + add_year;

   assign sc = (sec_ff >= SEC_WRAP);
   assign mc = (min_ff >= MIN_WRAP);
   assign hc = (hour_ff >= HOUR_WRAP);
   assign oc = (mon_ff >= MON_WRAP);
   assign yc = (ymod_ff >= CYCLE_YEARS);

   assign leap = (ymod_ff[1:0] == 2'b00) && !(ymod_ff inside {CENTURY_1, CENTURY_2, CENTURY_3});
   assign mlen = month_len(mon_ff[3:0], leap);
   assign day_big = (day_ff > DayWidth'(mlen));

   assign status.norm_done = !(sc || mc || hc || oc || yc);
   assign status.days_done = !day_big;

   always_comb begin
      sec_in = sec_ff;
      min_in = min_ff;
      hour_in = hour_ff;
      day_in = day_ff;
      mon_in = mon_ff;
      year_in = year_ff;
      ymod_in = ymod_ff;
      if (cmd.load) begin
         sec_in = WorkWidth'(req_data.in_second) + add_sec;
         min_in = WorkWidth'(req_data.in_minute) + add_min;
         hour_in = WorkWidth'(req_data.in_hour) + add_hour;
         day_in = DayWidth'(req_data.in_day) + add_day;
         mon_in = WorkWidth'(req_data.in_month) + add_mon;
         year_in = year_ld;
         ymod_in = year_ld + BASE_IN_CYCLE;
      end else if (cmd.run_norm) begin
         sec_in = sc ? sec_ff - SEC_WRAP : sec_ff;
         min_in = (mc ? min_ff - MIN_WRAP : min_ff) + WorkWidth'(sc);
         hour_in = (hc ? hour_ff - HOUR_WRAP : hour_ff) + WorkWidth'(mc);
         day_in = day_ff + DayWidth'(hc);
         mon_in = oc ? mon_ff - MON_WRAP : mon_ff;
         year_in = year_ff + WorkWidth'(oc);
         ymod_in = (yc ? ymod_ff - CYCLE_YEARS : ymod_ff) + WorkWidth'(oc);
      end else if (cmd.run_days && day_big) begin
         day_in = day_ff - DayWidth'(mlen);
         if (mon_ff == LAST_MONTH) begin
            mon_in = '0;
            year_in = year_ff + WorkWidth'(1);
            ymod_in = (ymod_ff == CYCLE_LAST) ? '0 : ymod_ff + WorkWidth'(1);
         end else begin
            mon_in = mon_ff + WorkWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      sec_ff <= sec_in;
      min_ff <= min_in;
      hour_ff <= hour_in;
      day_ff <= day_in;
      mon_ff <= mon_in;
      year_ff <= year_in;
      ymod_ff <= ymod_in;
      if (cmd.capture) begin
         rsp_ff.out_second <= sec_ff[5:0];
         rsp_ff.out_minute <= min_ff[5:0];
         rsp_ff.out_hour <= hour_ff[4:0];
         rsp_ff.out_day <= day_ff[4:0];
         rsp_ff.out_month <= mon_ff[3:0];
         rsp_ff.out_year <= year_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: src/calendar_interval_adder.sv
// Flow: an accepted input is loaded with the interval added, then carry passes run until
// every field is in range, then the day count is reduced one month at a time until it fits.
// The result is then captured into the output register once that register is free.
// The block works on one item at a time and takes no new item until its result is captured.
// A new item is taken while the previous result waits in the output register.
// Reset: synchronous, active high; clears the controller and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module calendar_interval_adder
   import cia_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [CountWidth-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   cia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cia_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: src/cia_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cia_checker
   import cia_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire rsp_type               rsp_data
);

   // A stalled result must hold its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The block works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every result has its second, minute, hour and month in range.
   a_rsp_normalized: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_second < 6'd60 && rsp_data.out_minute < 6'd60 &&
                    rsp_data.out_hour < 5'd24 && rsp_data.out_month < 4'd12)
      else $error("result not normalized");

endmodule

bind calendar_interval_adder cia_checker u_cia_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import cia_pkg::*;

   localparam int unsigned CycleLimit = 3000000;
   localparam int unsigned SettleCycles = 1500;
   localparam int unsigned PrintCap = 100;
   localparam int unsigned RandPhases = 12;
   localparam int unsigned PhaseItems = 46;

   typedef struct {
      logic [11:0] unit_raw;
      logic [11:0] count;
      req_type     item;
      bit          known;
      rsp_type     want;
   } date_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [CountWidth-1:0] csr_wdata;

   logic [2:0] cfg_unit;
   logic [11:0] cfg_count;
   rsp_type next_want;
   rsp_type date_q[$];
   date_row_type dir_rows[$];
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   int unsigned errors;
   int unsigned cycle_count;
   int unsigned items_taken;
   int unsigned dates_checked;
   int unsigned settings_used;

   calendar_interval_adder uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned days_in_month(int unsigned mon, int unsigned yr);
      int unsigned full;
      bit leap;
      full = yr + 1900;
      leap = ((full % 4) == 0 && (full % 100) != 0) || ((full % 400) == 0);
      if (mon == 1) begin
         return leap ? 29 : 28;
      end
      if (mon == 3 || mon == 5 || mon == 8 || mon == 10) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic rsp_type add_interval(req_type item, logic [2:0] unit,
                                            logic [11:0] count);
      int unsigned sec;
      int unsigned min;
      int unsigned hour;
      int unsigned day;
      int unsigned mon;
      int unsigned yr;
      int unsigned n;
      rsp_type res;
      sec = 32'(item.in_second);
      min = 32'(item.in_minute);
      hour = 32'(item.in_hour);
      day = 32'(item.in_day);
      mon = 32'(item.in_month);
      yr = 32'(item.in_year);
      n = 32'(count);
      case (unit_type'(unit))
         UNIT_SECOND: sec += n;
         UNIT_MINUTE: min += n;
         UNIT_HOUR: hour += n;
         UNIT_DAY: day += n;
         UNIT_WEEK: day += 7 * n;
         UNIT_MONTH: mon += n;
         UNIT_YEAR: yr += n;
         default: ;
      endcase
      min += sec / 60;
      sec %= 60;
      hour += min / 60;
      min %= 60;
      day += hour / 24;
      hour %= 24;
      yr += mon / 12;
      mon %= 12;
      while (day > days_in_month(mon, yr)) begin
         day -= days_in_month(mon, yr);
         mon++;
         if (mon > 11) begin
            mon = 0;
            yr++;
         end
      end
      res.out_second = sec[5:0];
      res.out_minute = min[5:0];
      res.out_hour = hour[4:0];
      res.out_day = day[4:0];
      res.out_month = mon[3:0];
      res.out_year = yr[12:0];
      return res;
   endfunction

   function automatic req_type make_date(int unsigned s, int unsigned m, int unsigned h,
                                         int unsigned d, int unsigned mo, int unsigned y);
      req_type item;
      item.in_second = s[5:0];
      item.in_minute = m[5:0];
      item.in_hour = h[4:0];
      item.in_day = d[4:0];
      item.in_month = mo[3:0];
      item.in_year = y[9:0];
      return item;
   endfunction

   function automatic req_type random_date();
      logic [63:0] raw;
      req_type item;
      if ($urandom_range(9) == 0) begin
         raw = {$urandom, $urandom};
         item = raw[35:0];
      end else begin
         item = make_date($urandom_range(59), $urandom_range(59), $urandom_range(23),
                          $urandom_range(1, 31), $urandom_range(11), $urandom_range(1023));
         if ($urandom_range(19) == 0) begin
            item.in_day = 5'd0;
         end
      end
      return item;
   endfunction

   task automatic add_row(logic [11:0] unit_raw, logic [11:0] count, req_type item,
                          bit known, req_type want_in, logic [12:0] want_year);
      date_row_type row;
      row.unit_raw = unit_raw;
      row.count = count;
      row.item = item;
      row.known = known;
      row.want.out_second = want_in.in_second;
      row.want.out_minute = want_in.in_minute;
      row.want.out_hour = want_in.in_hour;
      row.want.out_day = want_in.in_day;
      row.want.out_month = want_in.in_month;
      row.want.out_year = want_year;
      dir_rows.push_back(row);
   endtask

   task automatic report(string msg);
      errors++;
      if (errors <= PrintCap) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
      if (got !== want) begin
         report($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (date_q.size() != 0);
   endtask

   task automatic write_config(logic [11:0] unit_raw, logic [11:0] count);
      csr_we <= 1'b1;
      csr_index <= CSR_STEP_UNIT;
      csr_wdata <= unit_raw;
      @(negedge clock);
      csr_index <= CSR_STEP_COUNT;
      csr_wdata <= count;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_unit = unit_raw[2:0];
      cfg_count = count;
      settings_used++;
   endtask

   task automatic send_date(req_type item, bit known, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      next_want = known ? want : add_interval(item, cfg_unit, cfg_count);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            date_q.push_back(next_want);
            items_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (date_q.size() == 0) begin
               report("result with no item waiting for it");
            end else begin
               want = date_q.pop_front();
               check_field("out_second", 13'(rsp_data.out_second), 13'(want.out_second));
               check_field("out_minute", 13'(rsp_data.out_minute), 13'(want.out_minute));
               check_field("out_hour", 13'(rsp_data.out_hour), 13'(want.out_hour));
               check_field("out_day", 13'(rsp_data.out_day), 13'(want.out_day));
               check_field("out_month", 13'(rsp_data.out_month), 13'(want.out_month));
               check_field("out_year", rsp_data.out_year, want.out_year);
               dates_checked++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               date_q.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [11:0] unit_raw;
      logic [11:0] count;
      int unsigned pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_STEP_UNIT;
      csr_wdata = '0;
      next_want = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      errors = 0;
      cycle_count = 0;
      items_taken = 0;
      dates_checked = 0;
      settings_used = 1;
      cfg_unit = UNIT_RESET;
      cfg_count = COUNT_RESET;

      add_row(UNIT_SECOND, 90, make_date(0, 0, 0, 1, 0, 0), 1,
              make_date(30, 1, 0, 1, 0, 0), 0);
      add_row(UNIT_NONE, 0, make_date(59, 59, 23, 31, 11, 1023), 1,
              make_date(59, 59, 23, 31, 11, 0), 1023);
      add_row(UNIT_NONE, 0, make_date(63, 63, 31, 31, 15, 1023), 1,
              make_date(3, 4, 8, 2, 4, 0), 1024);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 0, 0, 0), 1, make_date(0, 0, 0, 0, 0, 0), 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 29, 1, 0), 0, '0, 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 29, 1, 100), 0, '0, 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 29, 1, 200), 0, '0, 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 29, 1, 4), 0, '0, 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 29, 13, 99), 0, '0, 0);
      add_row(UNIT_NONE, 0, make_date(0, 0, 0, 31, 3, 50), 0, '0, 0);
      add_row(UNIT_SECOND, 4095, make_date(63, 63, 31, 31, 15, 1023), 0, '0, 0);
      add_row(UNIT_SECOND, 0, make_date(59, 59, 23, 31, 11, 1023), 0, '0, 0);
      add_row(UNIT_MINUTE, 4095, make_date(0, 59, 23, 31, 11, 1023), 0, '0, 0);
      add_row(UNIT_HOUR, 4095, make_date(59, 59, 23, 1, 0, 0), 0, '0, 0);
      add_row(UNIT_DAY, 4095, make_date(0, 0, 0, 31, 0, 0), 0, '0, 0);
      add_row(UNIT_DAY, 1, make_date(59, 59, 23, 28, 1, 0), 0, '0, 0);
      add_row(UNIT_WEEK, 4095, make_date(63, 63, 31, 31, 15, 1023), 0, '0, 0);
      add_row(UNIT_WEEK, 1, make_date(0, 0, 0, 25, 11, 99), 0, '0, 0);
      add_row(UNIT_MONTH, 4095, make_date(0, 0, 0, 31, 15, 1023), 0, '0, 0);
      add_row(UNIT_MONTH, 1, make_date(0, 0, 0, 31, 0, 0), 0, '0, 0);
      add_row(UNIT_YEAR, 4095, make_date(0, 0, 0, 29, 1, 1023), 0, '0, 0);
      add_row(UNIT_YEAR, 1, make_date(0, 0, 0, 29, 1, 99), 0, '0, 0);
      add_row(12'hFFF, 4095, make_date(63, 0, 31, 0, 15, 0), 0, '0, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].unit_raw[2:0] != cfg_unit || dir_rows[i].count != cfg_count) begin
            drain_results();
            write_config(dir_rows[i].unit_raw, dir_rows[i].count);
         end
         send_date(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
      end

      for (int phase = 0; phase < RandPhases; phase++) begin
         drain_results();
         unit_raw = 12'($urandom_range(4095));
         if (phase < 8) begin
            unit_raw[2:0] = phase[2:0];
         end
         pick = $urandom_range(9);
         if (pick == 0) begin
            count = 12'd0;
         end else if (pick == 1) begin
            count = 12'd4095;
         end else if (pick < 4) begin
            count = 12'($urandom_range(4095));
         end else begin
            count = 12'($urandom_range(99));
         end
         write_config(unit_raw, count);
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               send_idle_pct = 13;
               stall_pct = 13;
            end
         endcase
         for (int k = 0; k < PhaseItems; k++) begin
            if (k == PhaseItems / 2 && phase % 3 == 0) begin
               drain_results();
            end
            send_date(random_date(), 0, '0);
         end
      end

      drain_results();
      repeat (SettleCycles) @(posedge clock);

      $display("Ran %0d items under %0d register settings; %0d results checked.",
               items_taken, settings_used, dates_checked);
      $display("All step units, zero and full counts, and four idle and stall mixes were used.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches found.", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
